@@ hdl/modbus_rtu_temp_link_unit_defines.svh @@
// Assertion helpers for the RTL
`ifndef MODBUS_RTU_TEMP_LINK_UNIT_DEFINES_SVH
`define MODBUS_RTU_TEMP_LINK_UNIT_DEFINES_SVH

// same-cycle implication, skipped while reset is low
`define MRTL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is low
`define MRTL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mrtl_pkg.sv @@
package mrtl_pkg;

  // item selector codes
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_RXBYTE = 2'd2;

  // register indexes (address bit 2)
  localparam logic REG_LINK_EN    = 1'b0;
  localparam logic REG_SLAVE_ADDR = 1'b1;

  // Modbus function codes and fixed frame fields
  localparam logic [7:0] MB_FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] MB_FC_WRITE_REG  = 8'h06;
  localparam logic [7:0] MB_RD_REG_HI     = 8'h00;
  localparam logic [7:0] MB_RD_REG_LO     = 8'h00;
  localparam logic [7:0] MB_RD_CNT_HI     = 8'h00;
  localparam logic [7:0] MB_RD_CNT_LO     = 8'h01;
  localparam logic [7:0] MB_WR_REG_HI     = 8'h01;
  localparam logic [7:0] MB_WR_REG_LO     = 8'h2C;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] PEND_MAX = 8'hFF;
  localparam logic [2:0] RX_POS_MAX = 3'd7;
  localparam logic [2:0] FRAME_LAST = 3'd7;
  localparam logic [2:0] FRAME_CRC_LO = 3'd6;

  // one decoded item, ready for serialization
  typedef struct packed {
    logic            is_frame;
    logic [5:0][7:0] bytes;     // bytes[0] goes out first
    logic            temp_valid;
    logic [15:0]     temp;
    logic [7:0]      pend;
  } desc_t;

  // fold one byte into the running CRC
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ hdl/mrtl_core.sv @@
module mrtl_core import mrtl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         func,
  input  logic signed [15:0] setpoint_tenths,
  input  logic [7:0]         rx_byte,
  input  logic               rx_first,
  input  logic               link_en,
  input  logic [7:0]         slave_addr,
  output desc_t              desc
);

  logic [15:0] temp_r, temp_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        match_r, match_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [2:0]  pos;

  // decode one item against the current link state
  always_comb begin
    temp_nxt  = temp_r;
    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    hi_nxt    = hi_r;
    desc      = '0;
    pos       = rx_first ? 3'd0 : pos_r;
    case (func)
      FUNC_READ: begin
        if (link_en) begin
          if (pend_r != PEND_MAX) pend_nxt = pend_r + 8'd1;
          desc.is_frame = 1'b1;
          desc.bytes[0] = slave_addr;
          desc.bytes[1] = MB_FC_READ_HOLD;
          desc.bytes[2] = MB_RD_REG_HI;
          desc.bytes[3] = MB_RD_REG_LO;
          desc.bytes[4] = MB_RD_CNT_HI;
          desc.bytes[5] = MB_RD_CNT_LO;
        end
      end
      FUNC_WRITE: begin
        if (link_en && setpoint_tenths != 16'sd0) begin
          desc.is_frame = 1'b1;
          desc.bytes[0] = slave_addr;
          desc.bytes[1] = MB_FC_WRITE_REG;
          desc.bytes[2] = MB_WR_REG_HI;
          desc.bytes[3] = MB_WR_REG_LO;
          desc.bytes[4] = setpoint_tenths[15:8];
          desc.bytes[5] = setpoint_tenths[7:0];
        end
      end
      FUNC_RXBYTE: begin
        // response tracking by byte position
        if (pos == 3'd1) begin
          match_nxt = (rx_byte == MB_FC_READ_HOLD);
        end else if (pos == 3'd3) begin
          hi_nxt = rx_byte;
        end else if (pos == 3'd4 && match_r) begin
          temp_nxt        = {hi_r, rx_byte};
          pend_nxt        = 8'd0;
          desc.temp_valid = 1'b1;
        end
        pos_nxt = (pos < RX_POS_MAX) ? pos + 3'd1 : RX_POS_MAX;
      end
      default: ;
    endcase
    desc.temp = link_en ? temp_nxt : 16'd0;
    desc.pend = pend_nxt;
  end

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r  <= '0;
      pend_r  <= '0;
      pos_r   <= '0;
      match_r <= 1'b0;
      hi_r    <= '0;
    end else if (accept) begin
      temp_r  <= temp_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

@@ hdl/mrtl_frame_tx.sv @@
module mrtl_frame_tx import mrtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  desc_t       item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_tx_last,
  output logic        out_temp_valid,
  output logic [15:0] out_present_temp_tenths,
  output logic [7:0]  out_pending_count,
  output logic [1:0]  q_count
);

  // two-entry descriptor queue
  desc_t       q_mem_r [2];
  logic        q_wr_r, q_rd_r;
  logic [1:0]  q_cnt_r, q_cnt_nxt;
  logic        q_push, q_pop;

  // serializer cursor
  logic        busy_r, busy_nxt;
  logic [2:0]  idx_r, idx_nxt;
  desc_t       cur_r;
  logic [15:0] crc_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        txv_r, last_r, tv_r;
  logic [15:0] temp_r;
  logic [7:0]  pend_r;

  logic [7:0]  cur_byte;
  logic        cur_last, out_free, push_out;

  assign item_ready = (q_cnt_r != 2'd2);
  assign q_push     = item_valid && item_ready;

  // byte under the cursor
  always_comb begin
    case (idx_r)
      3'd0:         cur_byte = cur_r.bytes[0];
      3'd1:         cur_byte = cur_r.bytes[1];
      3'd2:         cur_byte = cur_r.bytes[2];
      3'd3:         cur_byte = cur_r.bytes[3];
      3'd4:         cur_byte = cur_r.bytes[4];
      3'd5:         cur_byte = cur_r.bytes[5];
      FRAME_CRC_LO: cur_byte = crc_r[7:0];
      default:      cur_byte = crc_r[15:8];
    endcase
    if (!cur_r.is_frame) cur_byte = 8'd0;
  end

  assign cur_last = !cur_r.is_frame || (idx_r == FRAME_LAST);
  assign out_free = !out_valid_r || out_ready;
  assign push_out = busy_r && out_free;
  assign q_pop    = (q_cnt_r != 2'd0) && (!busy_r || (push_out && cur_last));

  // control next state
  always_comb begin
    q_cnt_nxt = q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (push_out) begin
      if (cur_last) busy_nxt = 1'b0;
      else          idx_nxt  = idx_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (push_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r      <= 1'b0;
      q_rd_r      <= 1'b0;
      q_cnt_r     <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_push) q_wr_r <= ~q_wr_r;
      if (q_pop)  q_rd_r <= ~q_rd_r;
      q_cnt_r     <= q_cnt_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: queue storage, cursor data, running CRC, result register
  always_ff @(posedge clk) begin
    if (q_push) q_mem_r[q_wr_r] <= item;
    if (q_pop) begin
      cur_r <= q_mem_r[q_rd_r];
      crc_r <= CRC_INIT;
    end else if (push_out && idx_r < FRAME_CRC_LO) begin
      crc_r <= crc_byte(crc_r, cur_byte);
    end
    if (push_out) begin
      byte_r <= cur_byte;
      txv_r  <= cur_r.is_frame;
      last_r <= cur_last;
      tv_r   <= cur_r.temp_valid;
      temp_r <= cur_r.temp;
      pend_r <= cur_r.pend;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_tx_byte             = byte_r;
  assign out_tx_valid            = txv_r;
  assign out_tx_last             = last_r;
  assign out_temp_valid          = tv_r;
  assign out_present_temp_tenths = temp_r;
  assign out_pending_count       = pend_r;
  assign q_count                 = q_cnt_r;

endmodule

@@ hdl/modbus_rtu_temp_link_unit.sv @@
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   func, setpoint_tenths, rx_byte, rx_first
// out_      output     out_valid / out_ready tx_byte, tx_valid, tx_last, temp_valid,
//                                            present_temp_tenths, pending_count
// APB       config     psel/penable/pready   link_enabled @0x0, slave_address @0x4
//
// A sent frame (read or write command) gives 8 results, one per cycle while not
// stalled, as the serializer steps one byte per cycle; every other item gives one
// result. The CRC is folded one byte per cycle while not stalled, as the first six
// bytes leave. Results are registered; a two-entry queue sits in front of the
// serializer. Reset (rst_n low, synchronous) resets the link state and the registers.
// A stalled out_ready holds the result register; input stalls once the queue is full.
`include "modbus_rtu_temp_link_unit_defines.svh"

module modbus_rtu_temp_link_unit import mrtl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_setpoint_tenths,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_rx_first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_valid,
  output logic               out_tx_last,
  output logic               out_temp_valid,
  output logic [15:0]        out_present_temp_tenths,
  output logic [7:0]         out_pending_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       link_en_r;
  logic [7:0] slave_addr_r;
  logic       cfg_wr, in_xfer;
  desc_t      desc;
  logic [1:0] q_count;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_en_r    <= 1'b0;
      slave_addr_r <= 8'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LINK_EN:    link_en_r    <= pwdata[0];
        REG_SLAVE_ADDR: slave_addr_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_LINK_EN:    prdata = {31'd0, link_en_r};
      REG_SLAVE_ADDR: prdata = {24'd0, slave_addr_r};
      default:        prdata = '0;
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  mrtl_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_xfer),
    .func            (in_func),
    .setpoint_tenths (in_setpoint_tenths),
    .rx_byte         (in_rx_byte),
    .rx_first        (in_rx_first),
    .link_en         (link_en_r),
    .slave_addr      (slave_addr_r),
    .desc            (desc)
  );

  mrtl_frame_tx u_tx (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .item_valid              (in_valid),
    .item_ready              (in_ready),
    .item                    (desc),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_tx_byte             (out_tx_byte),
    .out_tx_valid            (out_tx_valid),
    .out_tx_last             (out_tx_last),
    .out_temp_valid          (out_temp_valid),
    .out_present_temp_tenths (out_present_temp_tenths),
    .out_pending_count       (out_pending_count),
    .q_count                 (q_count)
  );

  // checks
  `MRTL_ASSERT_IMP(a_nontx_single, clk, rst_n, out_valid && !out_tx_valid, out_tx_last && out_tx_byte == 8'd0, "non-frame result must be a lone zero byte")
  `MRTL_ASSERT_IMP(a_temp_clears, clk, rst_n, out_valid && out_temp_valid, out_pending_count == 8'd0 && !out_tx_valid, "decoded temperature must clear pending count")
  `MRTL_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_count != 2'd3, "descriptor queue overflow")
  `MRTL_ASSERT_NXT(a_read_counts, clk, rst_n, in_xfer && in_func == FUNC_READ && link_en_r, u_core.pend_r != 8'd0, "read request not counted")

endmodule
